// ===== rtl/core/min_priority_task_queue_assert.svh =====
// assertion macros for the task queue
`ifndef MIN_PRIORITY_TASK_QUEUE_ASSERT_SVH
`define MIN_PRIORITY_TASK_QUEUE_ASSERT_SVH
`ifndef ASSERT_OFF
`define MTQ_ASSERT(label, clk, rstn, prop) \
    label: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error("assertion failed");
`define MTQ_ASSERT_NORST(label, clk, prop) \
    label: assert property (@(posedge clk) prop) else $error("assertion failed");
`else
`define MTQ_ASSERT(label, clk, rstn, prop)
`define MTQ_ASSERT_NORST(label, clk, prop)
`endif
`endif

// ===== rtl/core/mtq_pkg.sv =====
// shared types and codes of the task queue
package mtq_pkg;
    typedef struct packed {
        logic [15:0] score;
        logic [15:0] tag;
    } entry_t;

    typedef logic [1:0] status_t;
    localparam status_t STAT_OK        = 2'd0;
    localparam status_t STAT_POP_EMPTY = 2'd1;
    localparam status_t STAT_PUSH_FULL = 2'd2;

    localparam logic OP_PUSH = 1'b0;
    localparam logic OP_POP  = 1'b1;
endpackage

// ===== rtl/core/mtq_ram.sv =====
// task store: one write port, one registered read port
module mtq_ram #(
    parameter int DEPTH = 64,
    parameter int AW    = 6
) (
    input  logic            aclk,
    input  logic            we,
    input  logic [AW-1:0]   waddr,
    input  mtq_pkg::entry_t wdata,
    input  logic            re,
    input  logic [AW-1:0]   raddr,
    output mtq_pkg::entry_t rdata
);
    import mtq_pkg::*;

    entry_t mem [DEPTH];

    // write port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    // read port, registered
    always_ff @(posedge aclk) begin
        if (re) begin
            rdata <= mem[raddr];
        end
    end
endmodule

// ===== rtl/core/min_priority_task_queue.sv =====
// top level of the bounded min-score task queue
// Bounded priority queue of tasks (tag, score); a pop returns the lowest score,
// equal scores leave first in, first out.
// Input channel s_*: one request per handshake, s_op 0 pushes, 1 pops.
// Result channel m_*: exactly one result per request, in request order,
// carrying status, popped task, occupancy and empty flag.
// The store is a circular buffer in one RAM kept sorted by score.
// A pop reads the head entry, which passes through ST_POP_DATA and ST_FIN to the result.
// A push walks back from the tail, moving each entry with a greater score
// one place on (ST_PSH_RD, then ST_PSH_CMP, for each entry), then writes the new task.
// Errors (pop on empty, push on full) go from ST_IDLE straight to ST_FIN and the result stage.
// The next request is taken once the result stage has been loaded, while
// that result may still wait for the receiver.
// When m_ready stays low the finished result is held and the next request
// waits in its final stage; nothing is lost.
// Reset clears the count, head pointer and handshake state; the RAM needs
// no clearing since only written entries are ever read.
module min_priority_task_queue #(
    parameter int CAPACITY = 64
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_op,
    input  logic [15:0] s_task_tag,
    input  logic [15:0] s_score,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [1:0]  m_status,
    output logic [15:0] m_out_tag,
    output logic [15:0] m_out_score,
    output logic [6:0]  m_occupancy,
    output logic        m_queue_empty
);
    import mtq_pkg::*;

`include "min_priority_task_queue_assert.svh"

    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int SW = CW + 1;
    localparam logic [CW-1:0] CAP_C  = CW'(CAPACITY);
    localparam logic [AW-1:0] LAST_A = AW'(CAPACITY - 1);

    typedef enum logic [2:0] {
        ST_IDLE, ST_POP_DATA, ST_PSH_RD, ST_PSH_CMP, ST_FIN
    } state_t;

    state_t        state_reg, state_next;
    logic [CW-1:0] count_reg, count_next;
    logic [AW-1:0] head_reg, head_next;
    logic [AW-1:0] phys_reg, phys_next;
    logic [CW-1:0] pos_reg, pos_next;
    entry_t        new_reg, new_next;
    status_t       pend_status_reg, pend_status_next;
    entry_t        pend_reg, pend_next;
    logic          m_valid_reg, m_valid_next;
    status_t       m_status_reg, m_status_next;
    entry_t        m_task_reg, m_task_next;
    logic [6:0]    m_occ_reg, m_occ_next;
    logic          m_empty_reg, m_empty_next;

    logic          ram_we, ram_re;
    logic [AW-1:0] ram_waddr, ram_raddr;
    entry_t        ram_wdata, ram_rdata;

    logic [SW-1:0] tail_sum;
    logic [AW-1:0] tail_addr, phys_prev, head_succ;

    mtq_ram #(.DEPTH(CAPACITY), .AW(AW)) u_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // circular address arithmetic
    always_comb begin
        tail_sum = SW'(head_reg) + SW'(count_reg);
        if (tail_sum >= SW'(CAPACITY)) begin
            tail_sum = tail_sum - SW'(CAPACITY);
        end
        tail_addr = tail_sum[AW-1:0];
        phys_prev = (phys_reg == '0) ? LAST_A : phys_reg - AW'(1);
        head_succ = (head_reg == LAST_A) ? '0 : head_reg + AW'(1);
    end

    // sequencer
    always_comb begin
        state_next       = state_reg;
        count_next       = count_reg;
        head_next        = head_reg;
        phys_next        = phys_reg;
        pos_next         = pos_reg;
        new_next         = new_reg;
        pend_status_next = pend_status_reg;
        pend_next        = pend_reg;
        m_valid_next     = m_valid_reg && !m_ready;
        m_status_next    = m_status_reg;
        m_task_next      = m_task_reg;
        m_occ_next       = m_occ_reg;
        m_empty_next     = m_empty_reg;
        ram_we           = 1'b0;
        ram_re           = 1'b0;
        ram_waddr        = phys_reg;
        ram_raddr        = phys_prev;
        ram_wdata        = new_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    new_next  = '{score: s_score, tag: s_task_tag};
                    pend_next = '0;
                    if (s_op == OP_POP) begin
                        if (count_reg == '0) begin
                            pend_status_next = STAT_POP_EMPTY;
                            state_next       = ST_FIN;
                        end else begin
                            ram_re     = 1'b1;
                            ram_raddr  = head_reg;
                            state_next = ST_POP_DATA;
                        end
                    end else begin
                        if (count_reg >= CAP_C) begin
                            pend_status_next = STAT_PUSH_FULL;
                            state_next       = ST_FIN;
                        end else begin
                            phys_next  = tail_addr;
                            pos_next   = count_reg;
                            state_next = ST_PSH_RD;
                        end
                    end
                end
            end
            ST_POP_DATA: begin
                pend_next        = ram_rdata;
                pend_status_next = STAT_OK;
                head_next        = head_succ;
                count_next       = count_reg - CW'(1);
                state_next       = ST_FIN;
            end
            ST_PSH_RD: begin
                if (pos_reg == '0) begin
                    ram_we           = 1'b1;
                    count_next       = count_reg + CW'(1);
                    pend_status_next = STAT_OK;
                    state_next       = ST_FIN;
                end else begin
                    ram_re     = 1'b1;
                    state_next = ST_PSH_CMP;
                end
            end
            ST_PSH_CMP: begin
                ram_we = 1'b1;
                if (ram_rdata.score > new_reg.score) begin
                    // shift the larger entry one place towards the tail
                    ram_wdata  = ram_rdata;
                    phys_next  = phys_prev;
                    pos_next   = pos_reg - CW'(1);
                    state_next = ST_PSH_RD;
                end else begin
                    count_next       = count_reg + CW'(1);
                    pend_status_next = STAT_OK;
                    state_next       = ST_FIN;
                end
            end
            ST_FIN: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next  = 1'b1;
                    m_status_next = pend_status_reg;
                    m_task_next   = pend_reg;
                    m_occ_next    = 7'(count_reg);
                    m_empty_next  = (count_reg == '0);
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // state and result registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            count_reg   <= '0;
            head_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            head_reg    <= head_next;
            m_valid_reg <= m_valid_next;
        end
        phys_reg        <= phys_next;
        pos_reg         <= pos_next;
        new_reg         <= new_next;
        pend_status_reg <= pend_status_next;
        pend_reg        <= pend_next;
        m_status_reg    <= m_status_next;
        m_task_reg      <= m_task_next;
        m_occ_reg       <= m_occ_next;
        m_empty_reg     <= m_empty_next;
    end

    assign s_ready       = (state_reg == ST_IDLE);
    assign m_valid       = m_valid_reg;
    assign m_status      = m_status_reg;
    assign m_out_tag     = m_task_reg.tag;
    assign m_out_score   = m_task_reg.score;
    assign m_occupancy   = m_occ_reg;
    assign m_queue_empty = m_empty_reg;

    // checks
    `MTQ_ASSERT(a_count_bound, aclk, aresetn, count_reg <= CAP_C)
    `MTQ_ASSERT(a_empty_err, aclk, aresetn,
        (m_valid && m_status == STAT_POP_EMPTY) |-> m_queue_empty)
    `MTQ_ASSERT(a_full_err, aclk, aresetn,
        (m_valid && m_status == STAT_PUSH_FULL) |-> (m_occupancy == 7'(CAPACITY)))
    `MTQ_ASSERT(a_ram_order, aclk, aresetn, (state_reg == ST_PSH_CMP) |-> $past(ram_re))
endmodule

// ===== tb/tb_top.sv =====
// testbench for the bounded min-score task queue
`timescale 1ns / 1ps

module tb_top;
    import mtq_pkg::*;

    localparam int CAPACITY = 64;
    localparam int LIMIT_CYCLES = 2_000_000;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic        s_op = OP_PUSH;
    logic [15:0] s_task_tag = '0;
    logic [15:0] s_score = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [1:0]  m_status;
    logic [15:0] m_out_tag;
    logic [15:0] m_out_score;
    logic [6:0]  m_occupancy;
    logic        m_queue_empty;

    // one result per request
    typedef struct packed {
        status_t     status;
        logic [15:0] tag;
        logic [15:0] score;
        logic [6:0]  occupancy;
        logic        empty;
    } result_t;

    typedef struct {
        logic        op;
        logic [15:0] tag;
        logic [15:0] score;
        bit          typed;
        result_t     want;
    } row_t;

    // shadow of the sorted store
    entry_t  shadow_store[$];
    result_t pending_results[$];
    int      fail_count = 0;
    int      result_count = 0;
    int      full_count = 0;
    int      empty_count = 0;
    longint  cycle_count = 0;

    min_priority_task_queue #(.CAPACITY(CAPACITY)) dut (.*);

    always #5 aclk = ~aclk;

    // timeout watchdog
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > LIMIT_CYCLES) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // apply one request to the shadow store
    function automatic result_t queue_apply(logic op, logic [15:0] tag, logic [15:0] score);
        result_t r;
        int pos;
        entry_t e;
        r = '0;
        if (op == OP_PUSH) begin
            if (shadow_store.size() >= CAPACITY) begin
                r.status = STAT_PUSH_FULL;
            end else begin
                pos = shadow_store.size();
                while (pos > 0 && shadow_store[pos-1].score > score) pos--;
                e.score = score;
                e.tag = tag;
                shadow_store.insert(pos, e);
                r.status = STAT_OK;
            end
        end else begin
            if (shadow_store.size() == 0) begin
                r.status = STAT_POP_EMPTY;
            end else begin
                e = shadow_store.pop_front();
                r.status = STAT_OK;
                r.tag = e.tag;
                r.score = e.score;
            end
        end
        r.occupancy = 7'(shadow_store.size());
        r.empty = (shadow_store.size() == 0);
        return r;
    endfunction

    // send one request and queue its expected result
    task automatic send_request(logic op, logic [15:0] tag, logic [15:0] score,
                                bit typed, result_t want);
        result_t r;
        s_valid <= 1'b1;
        s_op <= op;
        s_task_tag <= tag;
        s_score <= score;
        do @(posedge aclk); while (!(s_valid && s_ready));
        r = queue_apply(op, tag, score);
        if (typed && r != want) begin
            $error("directed row disagrees with predictor: %h vs %h", want, r);
            fail_count++;
        end
        pending_results.push_back(typed ? want : r);
        @(negedge aclk);
    endtask

    task automatic idle_gap(int n);
        s_valid <= 1'b0;
        repeat (n) @(negedge aclk);
    endtask

    // receiver stalls on its own pattern, with calm stretches
    initial begin
        int phase;
        phase = 0;
        @(negedge aclk);
        while (!aresetn) @(negedge aclk);
        forever begin
            phase++;
            if ((phase / 200) % 3 == 2) m_ready <= 1'b1;
            else m_ready <= ($urandom_range(0, 3) != 0);
            @(negedge aclk);
        end
    end

    // result checker
    always @(posedge aclk) begin
        result_t w;
        if (aresetn && m_valid && m_ready) begin
            result_count++;
            if (pending_results.size() == 0) begin
                $error("result with no request outstanding");
                fail_count++;
            end else begin
                w = pending_results.pop_front();
                if (m_status != w.status) begin
                    $error("status expected %0d actual %0d", w.status, m_status);
                    fail_count++;
                end
                if (m_out_tag != w.tag) begin
                    $error("out_tag expected %0h actual %0h", w.tag, m_out_tag);
                    fail_count++;
                end
                if (m_out_score != w.score) begin
                    $error("out_score expected %0h actual %0h", w.score, m_out_score);
                    fail_count++;
                end
                if (m_occupancy != w.occupancy) begin
                    $error("occupancy expected %0d actual %0d", w.occupancy, m_occupancy);
                    fail_count++;
                end
                if (m_queue_empty != w.empty) begin
                    $error("queue_empty expected %0d actual %0d", w.empty, m_queue_empty);
                    fail_count++;
                end
                if (w.status == STAT_POP_EMPTY) empty_count++;
                if (w.status == STAT_PUSH_FULL) full_count++;
            end
        end
    end

    // stimulus
    initial begin
        row_t    rows[$];
        row_t    row;
        result_t none;
        int      burst;
        int      mode;
        int      k;
        int      wait_cycles;

        none = '0;
        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // directed table: typed rows carry their expected result
        rows.push_back('{OP_POP, 16'hffff, 16'hffff, 1,
                         '{STAT_POP_EMPTY, 16'h0, 16'h0, 7'd0, 1'b1}});
        rows.push_back('{OP_PUSH, 16'hffff, 16'hffff, 1,
                         '{STAT_OK, 16'h0, 16'h0, 7'd1, 1'b0}});
        rows.push_back('{OP_PUSH, 16'h0000, 16'h0000, 1,
                         '{STAT_OK, 16'h0, 16'h0, 7'd2, 1'b0}});
        rows.push_back('{OP_PUSH, 16'h1111, 16'h0005, 0, none});
        rows.push_back('{OP_PUSH, 16'h2222, 16'h0005, 0, none});
        rows.push_back('{OP_PUSH, 16'h3333, 16'h0005, 0, none});
        rows.push_back('{OP_POP, 16'h0, 16'h0, 1,
                         '{STAT_OK, 16'h0000, 16'h0000, 7'd4, 1'b0}});
        rows.push_back('{OP_POP, 16'h0, 16'h0, 1,
                         '{STAT_OK, 16'h1111, 16'h0005, 7'd3, 1'b0}});
        rows.push_back('{OP_POP, 16'h0, 16'h0, 0, none});
        rows.push_back('{OP_POP, 16'h0, 16'h0, 0, none});
        rows.push_back('{OP_POP, 16'h0, 16'h0, 1,
                         '{STAT_OK, 16'hffff, 16'hffff, 7'd0, 1'b1}});
        rows.push_back('{OP_POP, 16'h0, 16'h0, 1,
                         '{STAT_POP_EMPTY, 16'h0, 16'h0, 7'd0, 1'b1}});
        foreach (rows[i]) begin
            row = rows[i];
            send_request(row.op, row.tag, row.score, row.typed, row.want);
            if ($urandom_range(0, 2) == 0) idle_gap($urandom_range(1, 4));
        end

        // fill to capacity, then one push that overflows
        for (k = 0; k < CAPACITY + 1; k++)
            send_request(OP_PUSH, 16'($urandom), 16'($urandom_range(0, 7)), 0, none);

        // sender holds off until every result is in
        s_valid <= 1'b0;
        while (pending_results.size() != 0) @(negedge aclk);

        // random bursts: phases bias toward filling, draining or a mix
        k = 0;
        while (k < 620) begin
            mode = (k / 120) % 3;
            burst = $urandom_range(1, 16);
            repeat (burst) begin
                logic op;
                logic [15:0] sc;
                case (mode)
                    0: op = ($urandom_range(0, 9) < 2) ? OP_POP : OP_PUSH;
                    1: op = ($urandom_range(0, 9) < 8) ? OP_POP : OP_PUSH;
                    default: op = 1'($urandom_range(0, 1));
                endcase
                sc = ($urandom_range(0, 1) != 0) ? 16'($urandom_range(0, 15))
                                                 : 16'($urandom);
                send_request(op, 16'($urandom), sc, 0, none);
                k++;
            end
            if ($urandom_range(0, 3) != 0) idle_gap($urandom_range(1, 8));
        end
        s_valid <= 1'b0;

        // drain, then a short tail for stray results
        while (pending_results.size() != 0) @(negedge aclk);
        wait_cycles = 4 * CAPACITY + 20;
        repeat (wait_cycles) @(negedge aclk);

        $display("run: %0d results checked, %0d pops on empty, %0d pushes on full",
                 result_count, empty_count, full_count);
        if (fail_count == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end
endmodule

// ===== sim.f =====
+incdir+rtl/core
rtl/core/mtq_pkg.sv
rtl/core/mtq_ram.sv
rtl/core/min_priority_task_queue.sv
tb/tb_top.sv
